### sv/vsc_pkg.sv
package vsc_pkg;

   // grid geometry
   localparam int GRID_X      = 16;
   localparam int GRID_Y      = 16;
   localparam int GRID_Z      = 16;
   localparam int VOXEL_COUNT = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W      = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
   localparam int COORD_W     = 4;
   localparam int PLANE       = GRID_X * GRID_Y;

   // item codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // read sequence: centre voxel, then the six face neighbours
   localparam int NBR_W = 3;
   localparam logic [NBR_W-1:0] NB_CENTRE = 3'd0;
   localparam logic [NBR_W-1:0] NB_XM     = 3'd1;
   localparam logic [NBR_W-1:0] NB_XP     = 3'd2;
   localparam logic [NBR_W-1:0] NB_YM     = 3'd3;
   localparam logic [NBR_W-1:0] NB_YP     = 3'd4;
   localparam logic [NBR_W-1:0] NB_ZM     = 3'd5;
   localparam logic [NBR_W-1:0] NB_ZP     = 3'd6;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic               present_in;
   } req_type;

   typedef struct packed {
      logic present_out;
      logic on_surface;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_LAST,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             clear_step;
      logic             load;
      logic             write;
      logic             issue;
      logic [NBR_W-1:0] nbr;
      logic             take;
      logic             take_centre;
      logic             out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic req_query;
      logic in_grid;
      logic on_face;
      logic rsp_free;
   } sts_type;

   function automatic logic coord_inside(input logic [COORD_W-1:0] c, input int grid);
      return 32'(c) < grid;
   endfunction

   function automatic logic coord_on_face(input logic [COORD_W-1:0] c, input int grid);
      return (c == '0) || (32'(c) == grid - 1);
   endfunction

   function automatic logic [ADDR_W-1:0] voxel_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
      return ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(GRID_X) + ADDR_W'(z) * ADDR_W'(PLANE);
   endfunction

   // address of one voxel of the read sequence, centre must be interior
   function automatic logic [ADDR_W-1:0] nbr_addr(input logic [ADDR_W-1:0] centre,
                                                  input logic [NBR_W-1:0] nbr);
      logic [ADDR_W-1:0] a;
      unique case (nbr)
         NB_XM:   a = centre - ADDR_W'(1);
         NB_XP:   a = centre + ADDR_W'(1);
         NB_YM:   a = centre - ADDR_W'(GRID_X);
         NB_YP:   a = centre + ADDR_W'(GRID_X);
         NB_ZM:   a = centre - ADDR_W'(PLANE);
         NB_ZP:   a = centre + ADDR_W'(PLANE);
         default: a = centre;
      endcase
      return a;
   endfunction

endpackage

### sv/vsc_ram.sv
module vsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, read data registered and held between reads
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/vsc_ctrl.sv
module vsc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vsc_pkg::sts_type sts,
   output vsc_pkg::cmd_type cmd
);
   import vsc_pkg::*;

   state_type        state_ff, state_in;
   logic [NBR_W-1:0] idx_ff, idx_in;
   logic [NBR_W-1:0] last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= NB_CENTRE;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // face voxels need only the centre read
   assign last_idx = sts.on_face ? NB_CENTRE : NB_ZP;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = NB_CENTRE;
               state_in = sts.req_query ? ST_READ : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            if (!sts.in_grid) begin
               state_in = ST_FINISH;
            end else begin
               // issue one read, take the data of the previous one
               cmd.issue       = 1'b1;
               cmd.nbr         = idx_ff;
               cmd.take        = (idx_ff != NB_CENTRE);
               cmd.take_centre = (idx_ff == NB_XM);
               idx_in          = idx_ff + NBR_W'(1);
               if (idx_ff == last_idx) begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            cmd.take        = 1'b1;
            cmd.take_centre = (idx_ff == NB_XM);
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/vsc_datapath.sv
module vsc_datapath (
   input  logic             clock,
   input  logic             reset,
   input  vsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vsc_pkg::rsp_type rsp_data,
   input  vsc_pkg::cmd_type cmd,
   output vsc_pkg::sts_type sts
);
   import vsc_pkg::*;

   logic [ADDR_W-1:0] centre_ff, centre_in;
   logic              inside_ff, inside_in;
   logic              face_ff, face_in;
   logic              value_ff, value_in;
   logic              centre_bit_ff, centre_bit_in;
   logic              absent_ff, absent_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              mem_en, mem_we, mem_wdata, mem_rdata;
   logic [ADDR_W-1:0] mem_addr;

   // item registers
   always_comb begin
      centre_in = centre_ff;
      inside_in = inside_ff;
      face_in   = face_ff;
      value_in  = value_ff;
      if (cmd.load) begin
         centre_in = voxel_addr(req_data.pos_x, req_data.pos_y, req_data.pos_z);
         inside_in = coord_inside(req_data.pos_x, GRID_X)
                   & coord_inside(req_data.pos_y, GRID_Y)
                   & coord_inside(req_data.pos_z, GRID_Z);
         face_in   = coord_on_face(req_data.pos_x, GRID_X)
                   | coord_on_face(req_data.pos_y, GRID_Y)
                   | coord_on_face(req_data.pos_z, GRID_Z);
         value_in  = req_data.present_in;
      end
   end

   // presence of the centre and any absent neighbour
   always_comb begin
      centre_bit_in = centre_bit_ff;
      absent_in     = absent_ff;
      if (cmd.load) begin
         centre_bit_in = 1'b0;
         absent_in     = 1'b0;
      end else if (cmd.take) begin
         if (cmd.take_centre) begin
            centre_bit_in = mem_rdata;
         end else begin
            absent_in = absent_ff | ~mem_rdata;
         end
      end
   end

   // clearing pass address
   assign clr_in = cmd.clear_step ? clr_ff + ADDR_W'(1) : clr_ff;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.present_out = centre_bit_ff;
         rsp_data_in.on_surface  = centre_bit_ff & (face_ff | absent_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      centre_ff     <= centre_in;
      inside_ff     <= inside_in;
      face_ff       <= face_in;
      value_ff      <= value_in;
      centre_bit_ff <= centre_bit_in;
      absent_ff     <= absent_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // memory port
   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = 1'b0;
      mem_addr  = nbr_addr(centre_ff, cmd.nbr);
      priority if (cmd.clear_step) begin
         mem_en   = 1'b1;
         mem_we   = 1'b1;
         mem_addr = clr_ff;
      end else if (cmd.write) begin
         mem_en    = inside_ff;
         mem_we    = 1'b1;
         mem_wdata = value_ff;
         mem_addr  = centre_ff;
      end else if (cmd.issue) begin
         mem_en = 1'b1;
      end
   end

   vsc_ram #(
      .WIDTH (1),
      .DEPTH (VOXEL_COUNT)
   ) u_map (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign sts.clear_done = (clr_ff == ADDR_W'(VOXEL_COUNT - 1));
   assign sts.req_query  = (req_data.action == ACT_QUERY);
   assign sts.in_grid    = inside_ff;
   assign sts.on_face    = face_ff;
   assign sts.rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/voxel_surface_classifier.sv
// Voxel presence map of 16 x 16 x 16 bits in one single-port memory, addressed
// x + y*16 + z*256. A write beat sets or clears one voxel and returns nothing; a
// query beat returns the voxel's presence and whether it lies on the surface
// (present, and on a grid face or with any of its six face neighbours absent).
// After reset the block runs a clearing pass over all 4096 voxels, one voxel a
// cycle, with req_stall high. One item is worked at a time, one memory access a
// cycle: a query outside the grid makes no read, a query of a face voxel only the
// centre read and a query of an interior voxel seven reads of the single port.
// A finished result sits in an output register, so the next item is taken while
// it waits on rsp_stall.
module voxel_surface_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vsc_pkg::rsp_type rsp_data
);
   import vsc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   vsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import vsc_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_ITEMS     = 260;
   localparam int SETTLE_CYCLES   = 24;
   localparam int NBR_DX [7]      = '{0, -1, 1, 0, 0, 0, 0};
   localparam int NBR_DY [7]      = '{0, 0, 0, -1, 1, 0, 0};
   localparam int NBR_DZ [7]      = '{0, 0, 0, 0, 0, -1, 1};

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } vector_row_type;

   typedef struct {
      req_type query;
      rsp_type want;
   } query_outcome_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // own copy of the presence map, and the answers still to come
   bit                voxel_map [VOXEL_COUNT];
   query_outcome_type outcome_q [$];
   vector_row_type    directed_rows [$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int cycle_count;
   int writes_sent;
   int queries_sent;
   int hidden_seen;
   int surface_seen;

   voxel_surface_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_type make_item(logic act, int x, int y, int z, logic pin);
      req_type r;
      r.action     = act;
      r.pos_x      = COORD_W'(x);
      r.pos_y      = COORD_W'(y);
      r.pos_z      = COORD_W'(z);
      r.present_in = pin;
      return r;
   endfunction

   function automatic vector_row_type dir_row(logic act, int x, int y, int z, logic pin,
                                              bit fixed, logic po, logic os);
      vector_row_type v;
      v.item = make_item(act, x, y, z, pin);
      v.fixed = fixed;
      v.want.present_out = po;
      v.want.on_surface  = os;
      return v;
   endfunction

   function automatic bit voxel_at(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= GRID_X || y >= GRID_Y || z >= GRID_Z)
         return 1'b0;
      return voxel_map[x + y * GRID_X + z * PLANE];
   endfunction

   // applies one beat to the map; returns 1 with the answer for a query
   function automatic bit classify_voxel(input req_type item, output rsp_type answer);
      int x;
      int y;
      int z;
      bit inside_grid;
      bit on_face;
      x = int'(item.pos_x);
      y = int'(item.pos_y);
      z = int'(item.pos_z);
      inside_grid = x < GRID_X && y < GRID_Y && z < GRID_Z;
      answer = '0;
      if (item.action == ACT_WRITE) begin
         if (inside_grid)
            voxel_map[x + y * GRID_X + z * PLANE] = item.present_in;
         return 1'b0;
      end
      if (inside_grid && voxel_at(x, y, z)) begin
         answer.present_out = 1'b1;
         on_face = x == 0 || y == 0 || z == 0 ||
                   x == GRID_X - 1 || y == GRID_Y - 1 || z == GRID_Z - 1;
         if (on_face)
            answer.on_surface = 1'b1;
         else
            answer.on_surface = !voxel_at(x - 1, y, z) || !voxel_at(x + 1, y, z) ||
                                !voxel_at(x, y - 1, z) || !voxel_at(x, y + 1, z) ||
                                !voxel_at(x, y, z - 1) || !voxel_at(x, y, z + 1);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input req_type query,
                                  input rsp_type got, input rsp_type want);
      $display("mismatch at %0t: %s, voxel (%0d,%0d,%0d) got %b%b want %b%b",
               $realtime, what, query.pos_x, query.pos_y, query.pos_z,
               got.present_out, got.on_surface, want.present_out, want.on_surface);
      error_count++;
   endtask

   // one request beat, with an optional gap in front of it
   task automatic send_beat(input req_type item, input bit fixed, input rsp_type want);
      rsp_type           answer;
      query_outcome_type entry;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (classify_voxel(item, answer)) begin
         entry.query = item;
         entry.want  = fixed ? want : answer;
         outcome_q.push_back(entry);
         queries_sent++;
      end else begin
         writes_sent++;
      end
   endtask

   task automatic send_random(input req_type item);
      send_beat(item, 1'b0, rsp_type'('0));
   endtask

   // hold off the sender until every awaited answer has arrived
   task automatic drain_answers();
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   // mostly fill a voxel and six neighbours, query, punch a hole, query twice more
   task automatic build_block();
      int cx;
      int cy;
      int cz;
      int k;
      cx = $urandom_range(1, GRID_X - 2);
      cy = $urandom_range(1, GRID_Y - 2);
      cz = $urandom_range(1, GRID_Z - 2);
      for (k = 0; k < 7; k++)
         send_random(make_item(ACT_WRITE, cx + NBR_DX[k], cy + NBR_DY[k], cz + NBR_DZ[k],
                               $urandom_range(99) < 90));
      send_random(make_item(ACT_QUERY, cx, cy, cz, 1'($urandom_range(1))));
      k = $urandom_range(1, 6);
      send_random(make_item(ACT_WRITE, cx + NBR_DX[k], cy + NBR_DY[k], cz + NBR_DZ[k],
                            1'b0));
      send_random(make_item(ACT_QUERY, cx, cy, cz, 1'($urandom_range(1))));
      k = $urandom_range(0, 6);
      send_random(make_item(ACT_QUERY, cx + NBR_DX[k], cy + NBR_DY[k], cz + NBR_DZ[k],
                            1'($urandom_range(1))));
   endtask

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // result checker
   always @(posedge clock) begin
      query_outcome_type entry;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            entry.query = '0;
            entry.want  = '0;
            report_mismatch("result beat with nothing awaited", entry.query, rsp_data,
                            entry.want);
         end else begin
            entry = outcome_q.pop_front();
            if (rsp_data.present_out !== entry.want.present_out)
               report_mismatch("present_out", entry.query, rsp_data, entry.want);
            if (rsp_data.on_surface !== entry.want.on_surface)
               report_mismatch("on_surface", entry.query, rsp_data, entry.want);
            if (rsp_data.present_out && !rsp_data.on_surface)
               hidden_seen++;
            if (rsp_data.on_surface)
               surface_seen++;
         end
      end
   end

   initial begin
      int phase;
      int phase_start;
      int pick;
      int base_x;
      int base_y;
      int base_z;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      error_count   = 0;
      writes_sent   = 0;
      queries_sent  = 0;
      hidden_seen   = 0;
      surface_seen  = 0;
      send_idle_pct = 33;
      recv_idle_pct = 74;
      foreach (voxel_map[i]) voxel_map[i] = 1'b0;

      // directed rows: empty map, grid corners, faces, a fully enclosed voxel
      directed_rows.push_back(dir_row(ACT_QUERY, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 15, 15, 15, 1, 1, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 0, 0, 0, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 0, 0, 0, 0, 1, 1, 1));
      directed_rows.push_back(dir_row(ACT_WRITE, 15, 15, 15, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 15, 15, 15, 0, 1, 1, 1));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 5, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 5, 5, 5, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 4, 5, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 6, 5, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 4, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 6, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 5, 4, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 5, 6, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 5, 5, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 5, 4, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 5, 5, 5, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 5, 5, 5, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 5, 5, 5, 1, 1, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(ACT_WRITE, 15, 0, 15, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 15, 0, 15, 0, 1, 1, 1));
      directed_rows.push_back(dir_row(ACT_WRITE, 0, 7, 7, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(ACT_QUERY, 0, 7, 7, 0, 1, 1, 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      drain_answers();

      // random phases: sender idles less, then more, then neither side idles
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 74 : 0;
         recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 33 : 0;
         phase_start   = writes_sent + queries_sent;
         base_x = $urandom_range(0, GRID_X - 4);
         base_y = $urandom_range(0, GRID_Y - 4);
         base_z = $urandom_range(0, GRID_Z - 4);
         while (writes_sent + queries_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               // move the dense region now and then, faces included
               base_x = $urandom_range(0, GRID_X - 4);
               base_y = $urandom_range(0, GRID_Y - 4);
               base_z = $urandom_range(0, GRID_Z - 4);
            end else if (pick < 12) begin
               build_block();
            end else if (pick < 82) begin
               // dense 4x4x4 region, mostly filled, so interior voxels get enclosed
               send_random(make_item($urandom_range(99) < 45 ? ACT_QUERY : ACT_WRITE,
                                     base_x + $urandom_range(3), base_y + $urandom_range(3),
                                     base_z + $urandom_range(3), $urandom_range(99) < 75));
            end else begin
               send_random(req_type'($urandom));
            end
         end
         drain_answers();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $display("%0d answers never arrived", outcome_q.size());
         error_count++;
      end

      $display("covered %0d writes and %0d queries over three stall mixes",
               writes_sent, queries_sent);
      $display("answers on the surface %0d, enclosed interior voxels %0d",
               surface_seen, hidden_seen);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
